// ----- rtl/bgc_pkg.sv -----
`default_nettype none

package bgc_pkg;

   localparam int unsigned TICK_WIDTH    = 32;
   localparam int unsigned WINDOW_WIDTH  = 16;
   localparam int unsigned GESTURE_WIDTH = 3;

   localparam logic [WINDOW_WIDTH-1:0] LONG_HOLD_RESET_TICKS = 16'd500;
   localparam logic [WINDOW_WIDTH-1:0] REPRESS_RESET_TICKS   = 16'd1000;

   typedef enum logic [1:0] {
      PHASE_IDLE      = 2'd0,
      PHASE_HOLDING   = 2'd1,
      PHASE_LONG_HOLD = 2'd2,
      PHASE_REPRESS   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EVENT_NONE    = 2'd0,
      EVENT_PRESS   = 2'd1,
      EVENT_RELEASE = 2'd2,
      EVENT_HOLD    = 2'd3
   } event_type;

   typedef enum logic [GESTURE_WIDTH-1:0] {
      GESTURE_NONE    = 3'd0,
      GESTURE_REVERSE = 3'd1,
      GESTURE_UP      = 3'd2,
      GESTURE_CLICK   = 3'd3,
      GESTURE_DOWN    = 3'd4
   } gesture_type;

   localparam logic CSR_LONG_HOLD = 1'b0;
   localparam logic CSR_REPRESS   = 1'b1;

   localparam logic CLASSIFIED_BUTTON = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/button_gesture_classifier.sv -----
// Pipeline: an accepted request is held in the input register, then its gesture goes to
// the result register; a response stall holds both (input register, result register).
// Throughput: one request per cycle unless stalled; gesture state steps once per request.
// Reset: synchronous, active high; clears the valid of both stages, the gesture state and flags,
// and loads the long hold / re-press windows with 500 and 1000 ticks.
`default_nettype none

module button_gesture_classifier
   import bgc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [TICK_WIDTH-1:0]    req_now_tick,
   input  wire logic                     req_button_index,
   input  wire logic [1:0]               req_event_kind,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [GESTURE_WIDTH-1:0]      rsp_gesture_code,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic                     csr_index,
   input  wire logic [WINDOW_WIDTH-1:0]  csr_wdata
);

   // configuration
   logic [WINDOW_WIDTH-1:0] long_hold_ff, repress_ff;

   // input stage
   logic                  in_valid_ff, in_valid_in;
   logic [TICK_WIDTH-1:0] now_ff;
   logic                  button_ff;
   event_type             event_ff;

   // result stage
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [GESTURE_WIDTH-1:0] gesture_ff;

   // gesture state
   phase_type             phase_ff, phase_in;
   logic [TICK_WIDTH-1:0] stamp_ff, stamp_in;
   logic pressed_ff, pressed_in, prev_pressed_ff, prev_pressed_in;
   logic hold_ff, hold_in, long_hold_flag_ff, long_hold_flag_in;
   logic released_ff, released_in, click_ff, click_in;
   logic reverse_ff, reverse_in, checking_ff, checking_in;

   // state after the event and machine step, before the gesture pick
   phase_type             phase_adv;
   logic [TICK_WIDTH-1:0] stamp_adv;
   logic pressed_adv, hold_adv, long_hold_adv, released_adv;
   logic click_adv, reverse_adv, checking_adv;
   gesture_type           gesture_pick;

   logic advance, step;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gesture_code = gesture_ff;

   // event, then the phase machine
   always_comb begin
      phase_adv     = phase_ff;
      stamp_adv     = stamp_ff;
      pressed_adv   = pressed_ff;
      hold_adv      = hold_ff;
      long_hold_adv = long_hold_flag_ff;
      released_adv  = released_ff;
      click_adv     = click_ff;
      reverse_adv   = reverse_ff;
      checking_adv  = checking_ff;

      if (button_ff == CLASSIFIED_BUTTON) begin
         unique case (event_ff)
            EVENT_PRESS:   pressed_adv = 1'b1;
            EVENT_RELEASE: pressed_adv = 1'b0;
            EVENT_HOLD: begin
               hold_adv  = 1'b1;
               stamp_adv = now_ff;
            end
            default: ;
         endcase
      end

      if (hold_adv && phase_adv == PHASE_IDLE) begin
         stamp_adv = now_ff;
         phase_adv = PHASE_HOLDING;
      end

      priority if (prev_pressed_ff != pressed_adv && !pressed_adv
                   && phase_adv == PHASE_IDLE) begin
         click_adv = 1'b1;
      end else if (!pressed_adv && phase_adv == PHASE_HOLDING) begin
         released_adv = 1'b1;
         checking_adv = 1'b0;
         phase_adv    = PHASE_IDLE;
      end else if ((now_ff - stamp_adv) > {{(TICK_WIDTH-WINDOW_WIDTH){1'b0}}, long_hold_ff}
                   && phase_adv == PHASE_HOLDING) begin
         long_hold_adv = 1'b1;
         phase_adv     = PHASE_LONG_HOLD;
      end else begin
      end

      if (long_hold_adv && !pressed_adv) begin
         long_hold_adv = 1'b0;
         phase_adv     = PHASE_REPRESS;
         stamp_adv     = now_ff;
      end

      if (phase_adv == PHASE_REPRESS) begin
         priority if ((now_ff - stamp_adv)
                      > {{(TICK_WIDTH-WINDOW_WIDTH){1'b0}}, repress_ff}) begin
            phase_adv = PHASE_IDLE;
            if (!pressed_adv) begin
               released_adv = 1'b1;
               checking_adv = 1'b0;
            end
         end else if (pressed_adv && !prev_pressed_ff) begin
            // quick re-press after a long hold
            stamp_adv    = now_ff;
            reverse_adv  = 1'b1;
            checking_adv = 1'b1;
         end else begin
         end
      end
   end

   // gesture pick by priority; the reported flag is consumed
   always_comb begin
      gesture_pick = GESTURE_NONE;
      reverse_in   = reverse_adv;
      released_in  = released_adv;
      hold_in      = hold_adv;
      click_in     = click_adv;
      priority if (reverse_adv) begin
         gesture_pick = GESTURE_REVERSE;
         reverse_in   = 1'b0;
      end else if (released_adv) begin
         gesture_pick = GESTURE_UP;
         released_in  = 1'b0;
         hold_in      = 1'b0;
      end else if (click_adv) begin
         gesture_pick = GESTURE_CLICK;
         click_in     = 1'b0;
      end else if (hold_adv && !checking_adv) begin
         gesture_pick = GESTURE_DOWN;
         hold_in      = 1'b0;
      end else begin
      end
   end

   assign phase_in          = phase_adv;
   assign stamp_in          = stamp_adv;
   assign pressed_in        = pressed_adv;
   assign prev_pressed_in   = pressed_adv;
   assign long_hold_flag_in = long_hold_adv;
   assign checking_in       = checking_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         long_hold_ff      <= LONG_HOLD_RESET_TICKS;
         repress_ff        <= REPRESS_RESET_TICKS;
         phase_ff          <= PHASE_IDLE;
         stamp_ff          <= '0;
         pressed_ff        <= 1'b0;
         prev_pressed_ff   <= 1'b0;
         hold_ff           <= 1'b0;
         long_hold_flag_ff <= 1'b0;
         released_ff       <= 1'b0;
         click_ff          <= 1'b0;
         reverse_ff        <= 1'b0;
         checking_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_LONG_HOLD: long_hold_ff <= csr_wdata;
               CSR_REPRESS:   repress_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (step) begin
            phase_ff          <= phase_in;
            stamp_ff          <= stamp_in;
            pressed_ff        <= pressed_in;
            prev_pressed_ff   <= prev_pressed_in;
            hold_ff           <= hold_in;
            long_hold_flag_ff <= long_hold_flag_in;
            released_ff       <= released_in;
            click_ff          <= click_in;
            reverse_ff        <= reverse_in;
            checking_ff       <= checking_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         now_ff    <= req_now_tick;
         button_ff <= req_button_index;
         event_ff  <= event_type'(req_event_kind);
      end
      if (step) begin
         gesture_ff <= gesture_pick;
      end
   end

   a_long_hold_phase: assert property (@(posedge clock) disable iff (reset)
      long_hold_flag_ff |-> phase_ff == PHASE_LONG_HOLD)
      else $error("long hold flag outside long hold phase");

   a_step_gives_result: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_valid_ff && gesture_ff == $past(gesture_pick))
      else $error("processed request produced no result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff && phase_ff == PHASE_IDLE)
      else $error("reset did not clear pipeline and phase");

endmodule

`default_nettype wire

// ----- sim/bgc_gesture_checker.sv -----
module bgc_gesture_checker
   import bgc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [TICK_WIDTH-1:0]    req_now_tick,
   input  wire logic                     req_button_index,
   input  wire logic [1:0]               req_event_kind,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic [GESTURE_WIDTH-1:0] rsp_gesture_code,
   input  wire logic                     csr_valid,
   input  wire logic                     csr_ready,
   input  wire logic                     csr_index,
   input  wire logic [WINDOW_WIDTH-1:0]  csr_wdata,
   output int unsigned                   outstanding,
   output int unsigned                   error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [WINDOW_WIDTH-1:0] long_hold_ticks;
   logic [WINDOW_WIDTH-1:0] repress_window_ticks;

   phase_type             phase;
   logic [TICK_WIDTH-1:0] stamp;
   logic                  level;
   logic                  prev_level;
   logic                  hold_seen;
   logic                  long_hold_seen;
   logic                  up_pending;
   logic                  click_pending;
   logic                  reverse_pending;
   logic                  reverse_armed;

   gesture_type expected_gestures [$];

   // One poll: apply the event, step the gesture machine, report by priority.
   function automatic gesture_type classify_tick(input logic [TICK_WIDTH-1:0] now,
                                                 input logic button,
                                                 input event_type kind);
      logic [TICK_WIDTH-1:0] elapsed;
      if (button == CLASSIFIED_BUTTON) begin
         case (kind)
            EVENT_PRESS:   level = 1'b1;
            EVENT_RELEASE: level = 1'b0;
            EVENT_HOLD: begin
               hold_seen = 1'b1;
               stamp = now;
            end
            default: ;
         endcase
      end

      if (hold_seen && phase == PHASE_IDLE) begin
         stamp = now;
         phase = PHASE_HOLDING;
      end

      elapsed = now - stamp;
      if (prev_level != level && !level && phase == PHASE_IDLE) begin
         click_pending = 1'b1;
      end else if (!level && phase == PHASE_HOLDING) begin
         up_pending = 1'b1;
         reverse_armed = 1'b0;
         phase = PHASE_IDLE;
      end else if (elapsed > TICK_WIDTH'(long_hold_ticks) && phase == PHASE_HOLDING) begin
         long_hold_seen = 1'b1;
         phase = PHASE_LONG_HOLD;
      end

      if (long_hold_seen && !level) begin
         long_hold_seen = 1'b0;
         phase = PHASE_REPRESS;
         stamp = now;
      end

      if (phase == PHASE_REPRESS) begin
         elapsed = now - stamp;
         if (elapsed > TICK_WIDTH'(repress_window_ticks)) begin
            phase = PHASE_IDLE;
            if (!level) begin
               up_pending = 1'b1;
               reverse_armed = 1'b0;
            end
         end else if (level != prev_level && level) begin
            stamp = now;
            reverse_pending = 1'b1;
            reverse_armed = 1'b1;
         end
      end

      prev_level = level;

      if (reverse_pending) begin
         reverse_pending = 1'b0;
         return GESTURE_REVERSE;
      end
      if (up_pending) begin
         up_pending = 1'b0;
         hold_seen = 1'b0;
         return GESTURE_UP;
      end
      if (click_pending) begin
         click_pending = 1'b0;
         return GESTURE_CLICK;
      end
      if (hold_seen && !reverse_armed) begin
         hold_seen = 1'b0;
         return GESTURE_DOWN;
      end
      return GESTURE_NONE;
   endfunction

   always @(posedge clock) begin
      gesture_type want;
      if (reset) begin
         long_hold_ticks = LONG_HOLD_RESET_TICKS;
         repress_window_ticks = REPRESS_RESET_TICKS;
         phase = PHASE_IDLE;
         stamp = '0;
         level = 1'b0;
         prev_level = 1'b0;
         hold_seen = 1'b0;
         long_hold_seen = 1'b0;
         up_pending = 1'b0;
         click_pending = 1'b0;
         reverse_pending = 1'b0;
         reverse_armed = 1'b0;
         expected_gestures.delete();
         outstanding <= 0;
         error_count <= 0;
      end else begin
         // compare before predicting so a response can never match its own request
         if (rsp_valid && rsp_ready) begin
            if (expected_gestures.size() == 0) begin
               $display("%0t: gesture_code expected nothing, got %0d", $time, rsp_gesture_code);
               error_count <= error_count + 1;
            end else begin
               want = expected_gestures.pop_front();
               if (rsp_gesture_code !== want) begin
                  $display("%0t: gesture_code expected %0d, got %0d",
                           $time, want, rsp_gesture_code);
                  error_count <= error_count + 1;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LONG_HOLD: long_hold_ticks = csr_wdata;
               CSR_REPRESS:   repress_window_ticks = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_gestures.push_back(classify_tick(req_now_tick, req_button_index,
                                                      event_type'(req_event_kind)));
         outstanding <= expected_gestures.size();
      end
   end

endmodule

// ----- sim/tb_button_gesture_classifier.sv -----
module tb_button_gesture_classifier;
   timeunit 1ns;
   timeprecision 1ps;
   import bgc_pkg::*;

   localparam int unsigned SETTING_COUNT = 8;
   localparam int unsigned SETTING_ITEMS = 240;
   localparam int unsigned SETTLE_CYCLES = 10;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [TICK_WIDTH-1:0]    req_now_tick = '0;
   logic                     req_button_index = 1'b0;
   logic [1:0]               req_event_kind = EVENT_NONE;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [GESTURE_WIDTH-1:0] rsp_gesture_code;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic                     csr_index = CSR_LONG_HOLD;
   logic [WINDOW_WIDTH-1:0]  csr_wdata = '0;

   int unsigned outstanding;
   int unsigned error_count;

   logic [TICK_WIDTH-1:0]   tick_now = '0;
   logic [WINDOW_WIDTH-1:0] long_hold_cfg = LONG_HOLD_RESET_TICKS;
   logic [WINDOW_WIDTH-1:0] window_cfg = REPRESS_RESET_TICKS;
   logic                    req_gap_off = 1'b0;
   logic                    rsp_stall_off = 1'b0;
   int unsigned             sent = 0;

   always #5 clock = ~clock;

   button_gesture_classifier dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_now_tick     (req_now_tick),
      .req_button_index (req_button_index),
      .req_event_kind   (req_event_kind),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_gesture_code (rsp_gesture_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   bgc_gesture_checker gesture_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_now_tick     (req_now_tick),
      .req_button_index (req_button_index),
      .req_event_kind   (req_event_kind),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_gesture_code (rsp_gesture_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .outstanding      (outstanding),
      .error_count      (error_count)
   );

   // Call in step with clock; drives one request, after an optional random gap, until it is taken.
   task automatic send_at(input logic [TICK_WIDTH-1:0] now, input logic button,
                          input event_type kind);
      int unsigned gap;
      gap = req_gap_off ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      tick_now = now;
      req_valid <= 1'b1;
      req_now_tick <= now;
      req_button_index <= button;
      req_event_kind <= kind;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_csr(input logic index, input logic [WINDOW_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Tick step that lands on, just around, or well below a threshold.
   function automatic logic [TICK_WIDTH-1:0] step_near(input int unsigned limit);
      case ($urandom_range(0, 5))
         0: return 0;
         1: return limit;
         2: return limit + 1;
         3: return (limit == 0) ? 0 : limit - 1;
         4: return $urandom_range(0, 3);
         default: return $urandom_range(0, limit + 2);
      endcase
   endfunction

   task automatic run_gesture();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 15) == 0)
         req_gap_off = ~req_gap_off;
      if ($urandom_range(0, 15) == 0)
         rsp_stall_off = ~rsp_stall_off;

      if (pick < 2) begin
         // noise: any button, any event, now and then an arbitrary tick
         n = $urandom_range(1, 4);
         repeat (n)
            send_at(($urandom_range(0, 9) == 0) ? $urandom() : tick_now + $urandom_range(0, 50),
                    $urandom_range(0, 1), event_type'($urandom_range(0, 3)));
      end else if (pick < 4) begin
         send_at(tick_now + $urandom_range(0, 20), CLASSIFIED_BUTTON, EVENT_PRESS);
         repeat ($urandom_range(0, 2))
            send_at(tick_now + $urandom_range(0, 20), CLASSIFIED_BUTTON, EVENT_NONE);
         send_at(tick_now + $urandom_range(0, 20), CLASSIFIED_BUTTON, EVENT_RELEASE);
      end else begin
         send_at(tick_now + $urandom_range(0, 20), CLASSIFIED_BUTTON, EVENT_PRESS);
         send_at(tick_now + $urandom_range(0, 20), CLASSIFIED_BUTTON, EVENT_HOLD);
         send_at(tick_now + step_near(long_hold_cfg), CLASSIFIED_BUTTON, EVENT_NONE);
         repeat ($urandom_range(0, 2))
            send_at(tick_now + $urandom_range(0, 3), CLASSIFIED_BUTTON, EVENT_NONE);
         send_at(tick_now + $urandom_range(0, 3), CLASSIFIED_BUTTON, EVENT_RELEASE);
         // re-presses inside or just past the window
         n = $urandom_range(0, 3);
         repeat (n) begin
            send_at(tick_now + step_near(window_cfg), CLASSIFIED_BUTTON, EVENT_PRESS);
            send_at(tick_now + $urandom_range(0, 5), CLASSIFIED_BUTTON, EVENT_RELEASE);
         end
         send_at(tick_now + step_near(window_cfg), CLASSIFIED_BUTTON, EVENT_NONE);
      end
   endtask

   initial begin : rsp_side
      int unsigned stall;
      @(posedge clock iff !reset);
      forever begin
         stall = rsp_stall_off ? 0 : $urandom_range(0, 10);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int unsigned target;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, reset windows: 500 / 1000
      send_at(32'h0000_0000, 1'b0, EVENT_NONE);
      send_at(32'hFFFF_FFFF, CLASSIFIED_BUTTON, EVENT_NONE);
      send_at(32'd10, 1'b0, EVENT_PRESS);
      send_at(32'd11, 1'b0, EVENT_HOLD);
      send_at(32'd12, 1'b0, EVENT_RELEASE);
      send_at(32'd20, CLASSIFIED_BUTTON, EVENT_PRESS);
      send_at(32'd25, CLASSIFIED_BUTTON, EVENT_RELEASE);
      send_at(32'd100, CLASSIFIED_BUTTON, EVENT_PRESS);
      send_at(32'd101, CLASSIFIED_BUTTON, EVENT_HOLD);
      send_at(32'd400, CLASSIFIED_BUTTON, EVENT_NONE);
      send_at(32'd601, CLASSIFIED_BUTTON, EVENT_NONE);
      send_at(32'd602, CLASSIFIED_BUTTON, EVENT_NONE);
      send_at(32'd650, CLASSIFIED_BUTTON, EVENT_NONE);
      send_at(32'd700, CLASSIFIED_BUTTON, EVENT_RELEASE);
      send_at(32'd800, CLASSIFIED_BUTTON, EVENT_PRESS);
      send_at(32'd900, CLASSIFIED_BUTTON, EVENT_RELEASE);
      send_at(32'd1800, CLASSIFIED_BUTTON, EVENT_NONE);
      send_at(32'd1801, CLASSIFIED_BUTTON, EVENT_NONE);
      // hold across the 32-bit wrap
      send_at(32'hFFFF_FF00, CLASSIFIED_BUTTON, EVENT_PRESS);
      send_at(32'hFFFF_FF01, CLASSIFIED_BUTTON, EVENT_HOLD);
      send_at(32'h0000_01F5, CLASSIFIED_BUTTON, EVENT_NONE);
      send_at(32'h0000_0200, CLASSIFIED_BUTTON, EVENT_RELEASE);
      send_at(32'h0000_0200, CLASSIFIED_BUTTON, EVENT_HOLD);
      send_at(32'h0000_0300, CLASSIFIED_BUTTON, EVENT_NONE);

      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         drain();
         case (setting)
            0: begin long_hold_cfg = 16'd0;     window_cfg = 16'd0;     end
            1: begin long_hold_cfg = 16'd65535; window_cfg = 16'd65535; end
            2: begin long_hold_cfg = 16'd1;     window_cfg = 16'd2;     end
            3: begin long_hold_cfg = 16'd65535; window_cfg = 16'd0;     end
            4: begin long_hold_cfg = 16'd0;     window_cfg = 16'd65535; end
            5: begin long_hold_cfg = 16'd7;     window_cfg = 16'd12;    end
            default: begin
               long_hold_cfg = $urandom_range(0, 200);
               window_cfg = $urandom_range(0, 400);
            end
         endcase
         write_csr(CSR_LONG_HOLD, long_hold_cfg);
         write_csr(CSR_REPRESS, window_cfg);
         csr_valid <= 1'b0;
         // every other setting starts close enough to wrap the tick counter
         tick_now = setting[0] ? 32'hFFFF_FFFF - $urandom_range(0, 70000) : $urandom();
         req_gap_off = ($urandom_range(0, 3) == 0);
         rsp_stall_off = ($urandom_range(0, 3) == 0);
         target = sent + SETTING_ITEMS;
         while (sent < target)
            run_gesture();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : watchdog
      #(5_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/bgc_pkg.sv
rtl/button_gesture_classifier.sv
sim/bgc_gesture_checker.sv
sim/tb_button_gesture_classifier.sv
